// ===== sv/lbh_pkg.sv =====
// ----------------------------------------------------------------------------
// lbh_pkg
// Shared types, constants and helper functions for the log2 latency
// histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package lbh_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NumBucketsDef = 64;
  localparam int unsigned CountWidthDef = 32;

  // Bucket index width (buckets 0..63)
  localparam int unsigned BidxW = 6;
  localparam logic [BidxW-1:0] BidxMax = 6'd63;

  // Stream word layouts
  localparam int unsigned SampleW = 64;
  localparam int unsigned FracW   = 17;
  localparam int unsigned STdataW = 88;  // 64 + 17 bits, padded to bytes
  localparam int unsigned MTdataW = 72;  // 64 + 1 bits, padded to bytes

  // Request kinds carried in tuser
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Increment broadcast to the cell row
  typedef struct packed {
    logic             en;
    logic [BidxW-1:0] idx;
  } lbh_inc_t;

  // Search status handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [BidxW-1:0] idx;
  } lbh_tok_t;

  // Index of the highest set bit, zero maps to zero
  function automatic logic [BidxW-1:0] msb_index(input logic [SampleW-1:0] v);
    logic [BidxW-1:0] r;
    r = '0;
    for (int i = 1; i < SampleW; i++) begin
      if (v[i]) begin
        r = BidxW'(i);
      end
    end
    return r;
  endfunction

  // Upper bound 2^(i+1) of bucket i, all ones for the last bucket
  function automatic logic [SampleW-1:0] upper_bound(input logic [BidxW-1:0] i);
    logic [SampleW-1:0] r;
    if (i == BidxMax) begin
      r = '1;
    end else begin
      r = SampleW'(2) << i;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lbh_cell.sv =====
// ----------------------------------------------------------------------------
// lbh_cell
// One histogram bucket: holds its count and adds it to the running sum that
// travels down the row during a quantile search.
// ----------------------------------------------------------------------------
`default_nettype none

module lbh_cell #(
  parameter int unsigned COUNT_WIDTH = lbh_pkg::CountWidthDef,
  parameter int unsigned CELL_IDX    = 0
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire lbh_pkg::lbh_inc_t        inc_i,
  input  wire logic [lbh_pkg::BidxW-1:0] top_i,
  input  wire logic [COUNT_WIDTH-1:0]   target_i,
  input  wire logic [COUNT_WIDTH-1:0]   run_i,
  input  wire lbh_pkg::lbh_tok_t        tok_i,
  output logic      [COUNT_WIDTH-1:0]   run_o,
  output lbh_pkg::lbh_tok_t             tok_o
);

  localparam logic [lbh_pkg::BidxW-1:0] MyIdx = lbh_pkg::BidxW'(CELL_IDX);

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] sum;
  logic                   active;
  lbh_pkg::lbh_tok_t      tok_d;

  // Bump the count on a matching add
  always_comb begin
    count_d = count_q;
    if (inc_i.en && (inc_i.idx == MyIdx)) begin
      count_d = count_q + COUNT_WIDTH'(1);
    end
  end

  // Buckets above the top take no part in the search
  assign active = (MyIdx <= top_i);
  assign sum    = run_i + count_q;

  always_comb begin
    tok_d = tok_i;
    if (active && !tok_i.found && (sum >= target_i)) begin
      tok_d.found = 1'b1;
      tok_d.idx   = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hand the search word to the next cell
  always_ff @(posedge clk_i) begin
    run_o <= active ? sum : run_i;
    tok_o <= tok_d;
  end

endmodule

`default_nettype wire

// ===== sv/log2_latency_histogram.sv =====
// ----------------------------------------------------------------------------
// log2_latency_histogram
// Power-of-two bucket histogram of 64-bit samples with quantile lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_axis channel. tuser selects the request:
//   add a sample (tdata[63:0]) or query a quantile (tdata[80:64], q*65536).
//   An add gives no output word and leaves the block idle, so adds stream
//   back to back. A query gives one output word on m_axis: the bucket
//   upper bound in tdata[63:0] and the saturation flag in tdata[64].
//   A query first multiplies out the target; the search word then ripples
//   through the row of NUM_BUCKETS cells, and the result is loaded into the
//   output register. No input is taken while a query runs. The output word
//   sits in its own register, so the next add or query is accepted while a
//   finished result waits. If a second result is ready before the first is
//   taken, hold it and stall the input until the receiver takes the first.
//   Reset clears all bucket counts, the total and the saturation flag and
//   sets top_bucket to 63. Once the total count reaches its maximum,
//   further adds are dropped and the saturation flag is set until reset.
//   cfg_we_i/cfg_wdata_i write top_bucket. The user must do so only while
//   the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module log2_latency_histogram #(
  parameter int unsigned NUM_BUCKETS = lbh_pkg::NumBucketsDef,
  parameter int unsigned COUNT_WIDTH = lbh_pkg::CountWidthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration: top_bucket
  input  wire logic                        cfg_we_i,
  input  wire logic [lbh_pkg::BidxW-1:0]   cfg_wdata_i,
  // Request stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: sample_value [63:0], quantile_fraction [80:64], zero pad
  input  wire logic [lbh_pkg::STdataW-1:0] s_axis_tdata,
  // tuser: req_type [0]
  input  wire logic                        s_axis_tuser,
  // Result stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // tdata: quantile_bound [63:0], count_saturated [64], zero pad
  output logic [lbh_pkg::MTdataW-1:0]      m_axis_tdata
);

  localparam int unsigned StepW = $clog2(NUM_BUCKETS + 1);
  localparam int unsigned QW    = lbh_pkg::FracW - 1;  // fraction below 1.0
  localparam int unsigned PW    = COUNT_WIDTH + QW;
  localparam logic [lbh_pkg::BidxW-1:0] TopLimit = lbh_pkg::BidxW'(NUM_BUCKETS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WALK,
    ST_HOLD
  } state_e;

  state_e                        state_q;
  logic [lbh_pkg::BidxW-1:0]     top_q;
  logic [lbh_pkg::BidxW-1:0]     eff_top;
  logic [COUNT_WIDTH-1:0]        total_q;
  logic                          overflow_q;
  logic [lbh_pkg::FracW-1:0]     frac_q;
  logic [COUNT_WIDTH-1:0]        target_q;
  logic                          empty_q;
  logic [StepW-1:0]              step_q;
  logic [lbh_pkg::SampleW-1:0]   res_q;
  logic                          m_valid_q;
  logic [lbh_pkg::SampleW-1:0]   m_bound_q;
  logic                          m_sat_q;

  logic                          s_accept;
  logic                          is_add;
  logic                          total_full;
  logic [lbh_pkg::BidxW-1:0]     raw_idx;
  lbh_pkg::lbh_inc_t             inc;
  logic [PW-1:0]                 prod;
  logic [PW-1:0]                 prod_rnd;
  logic [COUNT_WIDTH-1:0]        target_raw;
  logic [COUNT_WIDTH-1:0]        target_d;
  logic                          walk_done;
  logic [lbh_pkg::SampleW-1:0]   result;
  logic                          out_free;
  logic                          out_load;

  logic [COUNT_WIDTH-1:0]        chain_run [NUM_BUCKETS+1];
  lbh_pkg::lbh_tok_t             chain_tok [NUM_BUCKETS+1];

  // Clamp the configured top to the buckets that exist
  always_comb begin
    eff_top = top_q;
    if (top_q > TopLimit) begin
      eff_top = TopLimit;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign is_add        = (s_axis_tuser == lbh_pkg::REQ_ADD);
  assign total_full    = (total_q == '1);

  // Bucket of an add: highest set bit, clamped to the top
  always_comb begin
    raw_idx = lbh_pkg::msb_index(s_axis_tdata[lbh_pkg::SampleW-1:0]);
    inc.en  = s_accept && is_add && !total_full;
    inc.idx = (raw_idx > eff_top) ? eff_top : raw_idx;
  end

  // target = max(1, ceil(q * total / 65536)); q of 1.0 or more gives total
  assign prod       = PW'(total_q) * PW'(frac_q[QW-1:0]);
  assign prod_rnd   = prod + PW'({QW{1'b1}});
  assign target_raw = frac_q[QW] ? total_q : prod_rnd[PW-1:QW];
  assign target_d   = (target_raw == '0) ? COUNT_WIDTH'(1) : target_raw;

  // Search word enters cell 0 empty
  assign chain_run[0] = '0;
  assign chain_tok[0] = '0;

  for (genvar k = 0; k < NUM_BUCKETS; k++) begin : g_cell
    lbh_cell #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .CELL_IDX    (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .inc_i    (inc),
      .top_i    (eff_top),
      .target_i (target_q),
      .run_i    (chain_run[k]),
      .tok_i    (chain_tok[k]),
      .run_o    (chain_run[k+1]),
      .tok_o    (chain_tok[k+1])
    );
  end

  // Last cell output is settled once the word has crossed the whole row
  assign walk_done = (state_q == ST_WALK) && (step_q == StepW'(NUM_BUCKETS));

  always_comb begin
    if (empty_q) begin
      result = '0;
    end else if (chain_tok[NUM_BUCKETS].found) begin
      result = lbh_pkg::upper_bound(chain_tok[NUM_BUCKETS].idx);
    end else begin
      result = lbh_pkg::upper_bound(eff_top);
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;
  // A finished or held result moves into the output register
  assign out_load = out_free && (walk_done || (state_q == ST_HOLD));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      top_q      <= lbh_pkg::BidxMax;
      total_q    <= '0;
      overflow_q <= 1'b0;
      frac_q     <= '0;
      target_q   <= '0;
      empty_q    <= 1'b0;
      step_q     <= '0;
      res_q      <= '0;
      m_valid_q  <= 1'b0;
      m_bound_q  <= '0;
      m_sat_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        top_q <= cfg_wdata_i;
      end

      // Load a new output word, or drop the current one once taken
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            if (is_add) begin
              if (total_full) begin
                overflow_q <= 1'b1;
              end else begin
                total_q <= total_q + COUNT_WIDTH'(1);
              end
            end else begin
              frac_q  <= s_axis_tdata[lbh_pkg::SampleW +: lbh_pkg::FracW];
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          target_q <= target_d;
          empty_q  <= (total_q == '0);
          step_q   <= '0;
          state_q  <= ST_WALK;
        end
        ST_WALK: begin
          step_q <= step_q + StepW'(1);
          if (walk_done) begin
            if (out_free) begin
              m_bound_q <= result;
              m_sat_q   <= overflow_q;
              state_q   <= ST_IDLE;
            end else begin
              res_q   <= result;
              state_q <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            m_bound_q <= res_q;
            m_sat_q   <= overflow_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {
    (lbh_pkg::MTdataW - lbh_pkg::SampleW - 1)'(0), m_sat_q, m_bound_q
  };

endmodule

`default_nettype wire
